// ----- hdl/chained_filter_prime_sieve_assert.svh -----
// assertion macros for the prime sieve checker
`ifndef CHAINED_FILTER_PRIME_SIEVE_ASSERT_SVH
`define CHAINED_FILTER_PRIME_SIEVE_ASSERT_SVH

// same-cycle implication
`define CFPS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cfps assertion failed");

// next-cycle implication
`define CFPS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cfps assertion failed");

`endif

// ----- hdl/cfps_pkg.sv -----
`timescale 1ns / 1ps

package cfps_pkg;

    localparam int          LIMIT_WIDTH     = 16;
    localparam int          CAND_START      = 2;
    localparam logic [15:0] END_LIMIT_RESET = 16'd20;

    typedef struct packed {
        logic accept;
        logic restart;
        logic advance;
        logic append;
    } cfps_ctl_t;

endpackage

// ----- hdl/cfps_cell.sv -----
`timescale 1ns / 1ps

module cfps_cell #(
    parameter int VALUE_WIDTH = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  cfps_pkg::cfps_ctl_t     ctl,
    input  logic [VALUE_WIDTH-1:0]  cand,
    input  logic                    prev_used,
    output logic                    used,
    output logic                    hit
);
    import cfps_pkg::*;

    logic                   used_reg;
    logic                   used_next;
    logic [VALUE_WIDTH-1:0] prime_reg;
    logic [VALUE_WIDTH-1:0] prime_next;
    logic [VALUE_WIDTH-1:0] rem_reg;
    logic [VALUE_WIDTH-1:0] rem_next;
    logic [VALUE_WIDTH-1:0] rem_inc;
    logic                   used_eff;
    logic                   slot;

    assign used_eff = used_reg & ~ctl.restart;
    assign slot     = prev_used & ~used_eff;
    assign used     = used_eff;
    assign hit      = used_eff & (rem_reg == '0);
    assign rem_inc  = rem_reg + VALUE_WIDTH'(1);

    always_comb
    begin
        used_next  = used_reg;
        prime_next = prime_reg;
        rem_next   = rem_reg;
        if (ctl.accept)
        begin
            used_next = used_eff;
            if (ctl.advance && used_eff)
            begin
                rem_next = (rem_inc == prime_reg) ? '0 : rem_inc;
            end
            if (ctl.append && slot)
            begin
                used_next  = 1'b1;
                prime_next = cand;
                rem_next   = VALUE_WIDTH'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
        end
        else
        begin
            used_reg <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prime_reg <= prime_next;
        rem_reg   <= rem_next;
    end

endmodule

// ----- hdl/chained_filter_prime_sieve.sv -----
`timescale 1ns / 1ps
// chained filter prime sieve
// tick channel: tick_valid / tick_stall with one field, restart; restart empties
//   the prime store and sets the candidate back to 2 before that tick is tested
// result channel: result_valid / result_stall with candidate, is_prime,
//   overflow and finished, one result item per tick item
// config: end_limit_we writes end_limit_wdata as the exclusive candidate bound
// the result is registered and shows in the cycle after the tick is taken
// throughput: one tick per cycle unless stalled; every cell of the chain keeps
//   its prime and the remainder of the next candidate, steps it in the same
//   cycle, and the divisor test is the or of the per-cell zero-remainder flags
// a survivor finds the first free cell through the used chain; with all
//   NUM_CELLS cells full it is reported with overflow and not stored
// at reset: no primes stored, candidate 2, end limit 20, no result pending
// while the receiver stalls a held result, tick_stall is high and no tick is
//   taken; the held result does not change
module chained_filter_prime_sieve #(
    parameter int NUM_CELLS   = 32,
    parameter int VALUE_WIDTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        end_limit_we,
    input  logic [15:0] end_limit_wdata,
    input  logic        tick_valid,
    output logic        tick_stall,
    input  logic        restart,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [15:0] candidate,
    output logic        is_prime,
    output logic        overflow,
    output logic        finished
);
    import cfps_pkg::*;

    localparam int CAND_W = VALUE_WIDTH + 1;
    localparam int CMP_W  = (CAND_W > LIMIT_WIDTH) ? CAND_W : LIMIT_WIDTH;

    logic [15:0]        end_limit_reg;
    logic [CAND_W-1:0]  cand_reg;
    logic [CAND_W-1:0]  cand_next;
    logic [CAND_W-1:0]  cand_eff;
    logic [CMP_W-1:0]   cand_wide;
    logic               result_valid_reg;
    logic               result_valid_next;
    logic [15:0]        candidate_reg;
    logic [15:0]        candidate_next;
    logic               is_prime_reg;
    logic               is_prime_next;
    logic               overflow_reg;
    logic               overflow_next;
    logic               finished_reg;
    logic               finished_next;

    logic               accept;
    logic               done;
    logic               any_hit;
    logic               full;
    logic [NUM_CELLS-1:0] used_vec;
    logic [NUM_CELLS-1:0] hit_vec;
    logic [NUM_CELLS-1:0] prev_vec;
    cfps_ctl_t          ctl;

    assign tick_stall = result_valid_reg & result_stall;
    assign accept     = tick_valid & ~tick_stall;

    assign cand_eff  = restart ? CAND_W'(CAND_START) : cand_reg;
    assign cand_wide = CMP_W'(cand_eff);
    assign done      = (cand_wide >= CMP_W'(end_limit_reg)) | cand_eff[VALUE_WIDTH];
    assign any_hit   = |hit_vec;
    assign full      = used_vec[NUM_CELLS-1];

    assign ctl.accept  = accept;
    assign ctl.restart = restart;
    assign ctl.advance = ~done;
    assign ctl.append  = ~done & ~any_hit;

    assign prev_vec[0] = 1'b1;

    genvar k;
    generate
        for (k = 1; k < NUM_CELLS; k++)
        begin : g_prev
            assign prev_vec[k] = used_vec[k-1];
        end
        for (k = 0; k < NUM_CELLS; k++)
        begin : g_cell
            cfps_cell #(
                .VALUE_WIDTH (VALUE_WIDTH)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl),
                .cand      (cand_eff[VALUE_WIDTH-1:0]),
                .prev_used (prev_vec[k]),
                .used      (used_vec[k]),
                .hit       (hit_vec[k])
            );
        end
    endgenerate

    always_comb
    begin
        cand_next         = cand_reg;
        result_valid_next = result_valid_reg;
        candidate_next    = candidate_reg;
        is_prime_next     = is_prime_reg;
        overflow_next     = overflow_reg;
        finished_next     = finished_reg;
        if (accept)
        begin
            result_valid_next = 1'b1;
            cand_next         = done ? cand_eff : cand_eff + CAND_W'(1);
            candidate_next    = done ? 16'd0 : cand_wide[15:0];
            is_prime_next     = ~done & ~any_hit;
            overflow_next     = ~done & ~any_hit & full;
            finished_next     = done;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            end_limit_reg    <= END_LIMIT_RESET;
            cand_reg         <= CAND_W'(CAND_START);
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (end_limit_we)
            begin
                end_limit_reg <= end_limit_wdata;
            end
            cand_reg         <= cand_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        candidate_reg <= candidate_next;
        is_prime_reg  <= is_prime_next;
        overflow_reg  <= overflow_next;
        finished_reg  <= finished_next;
    end

    assign result_valid = result_valid_reg;
    assign candidate    = candidate_reg;
    assign is_prime     = is_prime_reg;
    assign overflow     = overflow_reg;
    assign finished     = finished_reg;

endmodule

// ----- hdl/cfps_checker.sv -----
`timescale 1ns / 1ps

`include "chained_filter_prime_sieve_assert.svh"

module cfps_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        tick_valid,
    input logic        tick_stall,
    input logic        result_valid,
    input logic        result_stall,
    input logic [15:0] candidate,
    input logic        is_prime,
    input logic        overflow,
    input logic        finished
);

    // finished item carries nothing else
    `CFPS_ASSERT_NOW(a_finished_clean, result_valid && finished,
        candidate == 16'd0 && !is_prime && !overflow)

    // overflow only on a survivor
    `CFPS_ASSERT_NOW(a_overflow_prime, result_valid && overflow, is_prime && !finished)

    // every taken tick gives a result in the next cycle
    `CFPS_ASSERT_NEXT(a_tick_result, tick_valid && !tick_stall, result_valid)

    // a stalled result holds
    `CFPS_ASSERT_NEXT(a_result_hold, result_valid && result_stall,
        result_valid && $stable(candidate) && $stable(finished))

endmodule

bind chained_filter_prime_sieve cfps_checker u_cfps_checker (.*);

// ----- tb/sv/chained_filter_prime_sieve_tb.sv -----
`timescale 1ns / 1ps

module chained_filter_prime_sieve_tb;

    import cfps_pkg::*;

    localparam int STORE_DEPTH = 32;
    localparam int HOLD_CYCLES = 80;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_TICKS = 246;

    typedef struct packed {
        logic [LIMIT_WIDTH-1:0] candidate;
        logic                   is_prime;
        logic                   overflow;
        logic                   finished;
    } sieve_out_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   end_limit_we = 1'b0;
    logic [LIMIT_WIDTH-1:0] end_limit_wdata = '0;
    logic                   tick_valid = 1'b0;
    logic                   tick_stall;
    logic                   restart = 1'b0;
    logic                   result_valid;
    logic                   result_stall = 1'b0;
    logic [LIMIT_WIDTH-1:0] candidate;
    logic                   is_prime;
    logic                   overflow;
    logic                   finished;

    // sieve state as the testbench sees it
    int unsigned known_primes[STORE_DEPTH];
    int unsigned num_primes;
    int unsigned next_cand;
    int unsigned limit_q;

    logic       pending_ticks[$];
    sieve_out_t expected_results[$];

    bit calm = 1'b0;
    int hold_asked = 0;
    int hold_given = 0;
    int hold_left = 0;
    int idle_cycles = 0;
    int fails = 0;
    int ticks_sent = 0;
    int settings_run = 1;
    int primes_seen = 0;
    int overflows_seen = 0;
    int finished_seen = 0;

    wire tick_fire = tick_valid && !tick_stall;
    wire result_fire = result_valid && !result_stall;

    chained_filter_prime_sieve dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .end_limit_we    (end_limit_we),
        .end_limit_wdata (end_limit_wdata),
        .tick_valid      (tick_valid),
        .tick_stall      (tick_stall),
        .restart         (restart),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .candidate       (candidate),
        .is_prime        (is_prime),
        .overflow        (overflow),
        .finished        (finished)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic sieve_out_t sieve_tick(input logic rs);
        sieve_out_t r;
        logic       divided;
        r = '0;
        divided = 1'b0;
        if (rs)
        begin
            num_primes = 0;
            next_cand = CAND_START;
        end
        if (next_cand >= limit_q)
        begin
            r.finished = 1'b1;
            return r;
        end
        for (int k = 0; k < num_primes; k++)
            if (next_cand % known_primes[k] == 0)
                divided = 1'b1;
        r.candidate = next_cand[LIMIT_WIDTH-1:0];
        r.is_prime = !divided;
        if (!divided)
        begin
            if (num_primes < STORE_DEPTH)
            begin
                known_primes[num_primes] = next_cand;
                num_primes++;
            end
            else
                r.overflow = 1'b1;
        end
        next_cand++;
        return r;
    endfunction

    // tick driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_valid <= 1'b0;
            restart <= 1'b0;
        end
        else
        begin
            if (tick_fire)
            begin
                expected_results.push_back(sieve_tick(restart));
                void'(pending_ticks.pop_front());
                ticks_sent++;
            end
            if (!(tick_valid && tick_stall))
            begin
                if (pending_ticks.size() != 0 && (calm || $urandom_range(0, 99) >= 15))
                begin
                    tick_valid <= 1'b1;
                    restart <= pending_ticks[0];
                end
                else
                    tick_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        sieve_out_t want;
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            hold_left <= 0;
        end
        else
        begin
            if (result_fire)
            begin
                primes_seen += is_prime;
                overflows_seen += overflow;
                finished_seen += finished;
                if (expected_results.size() == 0)
                begin
                    $error("result item with nothing expected, candidate %0d", candidate);
                    fails++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (candidate !== want.candidate)
                    begin
                        $error("candidate: expected %0d, got %0d", want.candidate, candidate);
                        fails++;
                    end
                    if (is_prime !== want.is_prime)
                    begin
                        $error("is_prime: expected %0b, got %0b", want.is_prime, is_prime);
                        fails++;
                    end
                    if (overflow !== want.overflow)
                    begin
                        $error("overflow: expected %0b, got %0b", want.overflow, overflow);
                        fails++;
                    end
                    if (finished !== want.finished)
                    begin
                        $error("finished: expected %0b, got %0b", want.finished, finished);
                        fails++;
                    end
                end
            end
            if (hold_asked != hold_given)
            begin
                hold_given <= hold_given + 1;
                hold_left <= HOLD_CYCLES;
                result_stall <= 1'b1;
            end
            else if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                result_stall <= 1'b1;
            end
            else
                result_stall <= !calm && ($urandom_range(0, 99) < 15);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (tick_fire || result_fire)
                idle_cycles <= 0;
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("timeout with %0d results outstanding", expected_results.size());
                $display("Some tests failed");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic push_tick(input logic rs);
        pending_ticks.push_back(rs);
    endtask

    task automatic wait_drained();
        while (pending_ticks.size() != 0 || expected_results.size() != 0 || tick_valid)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_limit(input logic [LIMIT_WIDTH-1:0] value);
        @(posedge clk);
        end_limit_we <= 1'b1;
        end_limit_wdata <= value;
        @(posedge clk);
        end_limit_we <= 1'b0;
        limit_q = value;
        settings_run++;
    endtask

    initial
    begin
        logic [LIMIT_WIDTH-1:0] lim;
        int                     chance;
        num_primes = 0;
        next_cand = CAND_START;
        limit_q = END_LIMIT_RESET;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // reset limit: walk the whole range, run past the end, then restart
        for (int i = 0; i < 20; i++)
            push_tick(1'b0);
        push_tick(1'b1);
        push_tick(1'b0);
        push_tick(1'b0);
        wait_drained();

        // smallest limit finishes at once
        write_limit(16'd2);
        push_tick(1'b1);
        push_tick(1'b0);
        wait_drained();

        for (int p = 0; p < 7; p++)
        begin
            case (p)
                0: lim = 16'hffff;
                1: lim = 16'd200;
                2: lim = 16'd3;
                3: lim = 16'($urandom_range(4, 40));
                4: lim = 16'($urandom_range(2, 65535));
                5: lim = 16'd150;
                default: lim = 16'hffff;
            endcase
            chance = (p == 2 || p == 3) ? 8 : ((p == 4) ? 1 : 0);
            write_limit(lim);
            calm = (p == 5);
            // long receiver hold while ticks keep coming
            if (p == 1)
                hold_asked = hold_asked + 1;
            for (int i = 0; i < PHASE_TICKS; i++)
                push_tick((i == 0 && p != 0) || $urandom_range(0, 99) < chance);
            wait_drained();
        end

        calm = 1'b0;
        wait_drained();
        $display("%0d tick items checked over %0d end limit settings", ticks_sent,
            settings_run);
        $display("%0d primes, %0d overflows, %0d finished ticks seen", primes_seen,
            overflows_seen, finished_seen);
        if (fails == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/cfps_pkg.sv
hdl/cfps_cell.sv
hdl/chained_filter_prime_sieve.sv
hdl/cfps_checker.sv
tb/sv/chained_filter_prime_sieve_tb.sv
